>>> sv/lfu_pkg.sv
// Package for the LFU node cache directory.
// Holds the field widths, status codes and the compare unit's result type.
// Depends on nothing; every other file imports it.
package lfu_pkg;

	localparam int TAG_W   = 32;
	localparam int COUNT_W = 32;
	localparam int SLOT_W  = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_WMISS = 2'd2;
	localparam logic [1:0] ST_FAIL  = 2'd3;

	typedef struct packed {
		logic               match;
		logic               le;
		logic [COUNT_W-1:0] cnt_inc;
	} cmp_res_t;

endpackage

>>> sv/lfu_dir_mem.sv
// Tag and use-count storage of the directory: one write address, one read
// address, registered read data. Depends on lfu_pkg for the field widths.
module lfu_dir_mem #(
	parameter int ENTRIES = 8,
	parameter int AW      = 3
) (
	input  logic                         clk,
	input  logic [AW-1:0]                raddr,
	input  logic [AW-1:0]                waddr,
	input  logic                         we_tag,
	input  logic                         we_cnt,
	input  logic [lfu_pkg::TAG_W-1:0]    wtag,
	input  logic [lfu_pkg::COUNT_W-1:0]  wcnt,
	output logic [lfu_pkg::TAG_W-1:0]    rtag,
	output logic [lfu_pkg::COUNT_W-1:0]  rcnt
);
	import lfu_pkg::*;

	logic [TAG_W-1:0]   tag_mem [ENTRIES];
	logic [COUNT_W-1:0] cnt_mem [ENTRIES];
	logic [TAG_W-1:0]   rtag_q;
	logic [COUNT_W-1:0] rcnt_q;

	always_ff @(posedge clk) begin
		if (we_tag) begin
			tag_mem[waddr] <= wtag;
		end
		if (we_cnt) begin
			cnt_mem[waddr] <= wcnt;
		end
		rtag_q <= tag_mem[raddr];
		rcnt_q <= cnt_mem[raddr];
	end

	assign rtag = rtag_q;
	assign rcnt = rcnt_q;

endmodule

>>> sv/lfu_cmp_unit.sv
// Shared compare unit: tag match, least-count compare and saturating bump.
// Used once per scanned entry. Depends on lfu_pkg.
module lfu_cmp_unit (
	input  logic [lfu_pkg::TAG_W-1:0]   tag,
	input  logic [lfu_pkg::COUNT_W-1:0] cnt,
	input  logic [lfu_pkg::TAG_W-1:0]   pos,
	input  logic [lfu_pkg::COUNT_W-1:0] lowest,
	output lfu_pkg::cmp_res_t           res
);
	import lfu_pkg::*;

	always_comb begin
		res.match   = (tag == pos);
		res.le      = (cnt <= lowest);
		res.cnt_inc = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + COUNT_ONE;
	end

endmodule

>>> sv/lfu_node_cache_directory_top.sv
// Top level of the LFU node cache directory.
// Uses lfu_pkg, lfu_dir_mem and lfu_cmp_unit.
//
// The block looks up node positions in a small fully associative directory.
// A request item is taken at a rising edge where start is high and busy is
// low; its fields are req_type, node_pos and fetch_ok. Busy then stays high
// while a small sequencer walks the filled entries one per cycle through a
// single compare unit, reading the tag and use-count memory at one address
// each cycle with registered read data.
// The walk stops at the first matching entry. A hit bumps the entry's count
// (saturating). A read miss with a good fetch fills the next empty entry, or
// once all are full the entry with the smallest count, the last on a tie,
// and sets its count to one. Writes never allocate.
// The result item (status, slot) appears for exactly one cycle, marked by
// done, in the same cycle that busy falls; the receiver cannot stall it, so it
// must take it then. A new request may be given in that same cycle.
// Reset clears the fill count and the sequencer; the memories are not
// cleared because only filled entries are ever compared.
module lfu_node_cache_directory_top #(
	parameter int CACHE_ENTRIES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              req_type,
	input  logic [lfu_pkg::TAG_W-1:0]         node_pos,
	input  logic                              fetch_ok,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [lfu_pkg::SLOT_W-1:0]        slot
);
	import lfu_pkg::*;

	// AW indexes an entry; IW also holds the entry count itself.
	localparam int AW = $clog2(CACHE_ENTRIES);
	localparam int IW = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IW-1:0] FULL = IW'(CACHE_ENTRIES);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic               state_q;
	logic [IW-1:0]      fill_q;
	logic [IW-1:0]      idx_q;
	logic               data_vld_q;
	logic [AW-1:0]      data_idx_q;
	logic [COUNT_W-1:0] lowest_q;
	logic [AW-1:0]      victim_q;

	// Latched request.
	logic               req_type_q;
	logic [TAG_W-1:0]   pos_q;
	logic               fetch_ok_q;

	// Result registers.
	logic               done_q;
	logic [1:0]         status_q;
	logic [SLOT_W-1:0]  slot_q;

	logic [TAG_W-1:0]   rtag;
	logic [COUNT_W-1:0] rcnt;
	cmp_res_t           cmp;

	logic               accept;
	logic               issue;
	logic               hit_now;
	logic               finish;
	logic               do_fill;
	logic               take;
	logic [COUNT_W-1:0] cur_low;
	logic [AW-1:0]      cur_vic;
	logic [AW-1:0]      waddr;
	logic               we_tag;
	logic               we_cnt;
	logic [COUNT_W-1:0] wcnt;
	logic [1:0]         res_status;

	assign accept = start && (state_q == S_IDLE);

	lfu_dir_mem #(
		.ENTRIES (CACHE_ENTRIES),
		.AW      (AW)
	) u_mem (
		.clk    (clk),
		.raddr  (idx_q[AW-1:0]),
		.waddr  (waddr),
		.we_tag (we_tag),
		.we_cnt (we_cnt),
		.wtag   (pos_q),
		.wcnt   (wcnt),
		.rtag   (rtag),
		.rcnt   (rcnt)
	);

	lfu_cmp_unit u_cmp (
		.tag    (rtag),
		.cnt    (rcnt),
		.pos    (pos_q),
		.lowest (lowest_q),
		.res    (cmp)
	);

	// Each scan cycle issues a read of entry idx_q while unread filled entries
	// remain, and compares the data of the entry read in the cycle before. The
	// walk ends on a match, or once every filled entry is read and compared.
	always_comb begin
		issue   = (state_q == S_SCAN) && (idx_q != fill_q);
		hit_now = (state_q == S_SCAN) && data_vld_q && cmp.match;
		finish  = (state_q == S_SCAN) && (hit_now || (idx_q == fill_q));

		// Running least-count victim, including the entry compared now.
		take    = data_vld_q && !cmp.match && cmp.le;
		cur_low = take ? rcnt : lowest_q;
		cur_vic = take ? data_idx_q : victim_q;

		do_fill = finish && !hit_now && !req_type_q && fetch_ok_q;

		if (hit_now) begin
			waddr = data_idx_q;
		end else if (fill_q == FULL) begin
			waddr = cur_vic;
		end else begin
			waddr = fill_q[AW-1:0];
		end

		we_tag = do_fill;
		we_cnt = do_fill || hit_now;
		wcnt   = hit_now ? cmp.cnt_inc : COUNT_ONE;

		if (hit_now) begin
			res_status = ST_HIT;
		end else if (req_type_q) begin
			res_status = ST_WMISS;
		end else if (!fetch_ok_q) begin
			res_status = ST_FAIL;
		end else begin
			res_status = ST_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			data_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_SCAN;
						idx_q      <= '0;
						data_vld_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (finish) begin
						state_q    <= S_IDLE;
						done_q     <= 1'b1;
						data_vld_q <= 1'b0;
						if (do_fill && (fill_q != FULL)) begin
							fill_q <= fill_q + IW'(1);
						end
					end else begin
						data_vld_q <= issue;
						if (issue) begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, scan and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			pos_q      <= node_pos;
			fetch_ok_q <= fetch_ok;
			lowest_q   <= COUNT_MAX;
			victim_q   <= '0;
		end else if (state_q == S_SCAN) begin
			lowest_q <= cur_low;
			victim_q <= cur_vic;
		end
		if (state_q == S_SCAN) begin
			data_idx_q <= idx_q[AW-1:0];
		end
		if (finish) begin
			status_q <= res_status;
			if (hit_now || do_fill) begin
				slot_q <= SLOT_W'(waddr);
			end else begin
				slot_q <= '0;
			end
		end
	end

	assign busy   = (state_q == S_SCAN);
	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule

>>> sv/lfu_dir_checker.sv
// Port-level checker for the LFU node cache directory, bound to the top
// level. Depends on lfu_pkg for the status codes.
module lfu_dir_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [1:0]                 status,
	input logic [lfu_pkg::SLOT_W-1:0] slot
);
	import lfu_pkg::*;

	// An accepted item keeps the block busy for at least the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	// The end of a lookup always shows a result in the same cycle.
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("lookup ended without a result");

	// No result is shown while a lookup is still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Results that touch no entry report slot zero.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_WMISS || status == ST_FAIL)) |-> (slot == '0))
		else $error("non-cached result carries a slot");

endmodule

bind lfu_node_cache_directory_top lfu_dir_checker u_lfu_dir_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.slot   (slot)
);
